// ===== rtl/core/keyed_xorshift_stream_xor_macros.svh =====
// Assertion macros for the keyed xorshift stream XOR block
`ifndef KEYED_XORSHIFT_STREAM_XOR_MACROS_SVH
`define KEYED_XORSHIFT_STREAM_XOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KXS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KXS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kxs_pkg.sv =====
// Shared types, constants and microcode ROM for the keyed xorshift stream XOR block
package kxs_pkg;

    localparam logic [63:0] SEED_CONST = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_CONST  = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [31:0] MIX_LO     = MIX_CONST[31:0];
    localparam logic [31:0] MIX_HI     = MIX_CONST[63:32];
    localparam int          FOLD_SHIFT = 33;
    localparam int          XS_A       = 13;
    localparam int          XS_B       = 7;
    localparam int          XS_C       = 17;

    localparam int KEY_ROUNDS = 16;
    localparam int ROUND_W    = $clog2(KEY_ROUNDS);
    localparam int PC_W       = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(KEY_ROUNDS - 1);

    localparam logic [0:0] REG_KEY_LOW  = 1'b0;
    localparam logic [0:0] REG_KEY_HIGH = 1'b1;

    localparam logic [PC_W-1:0] ADDR_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] ADDR_SEED   = 3'd1;
    localparam logic [PC_W-1:0] ADDR_ABSORB = 3'd2;
    localparam logic [PC_W-1:0] ADDR_MUL_LL = 3'd3;
    localparam logic [PC_W-1:0] ADDR_MUL_LH = 3'd4;
    localparam logic [PC_W-1:0] ADDR_MUL_HL = 3'd5;
    localparam logic [PC_W-1:0] ADDR_FOLD   = 3'd6;
    localparam logic [PC_W-1:0] ADDR_STEP   = 3'd7;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_SEED,
        OP_ABSORB,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_FOLD,
        OP_STEP
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ACCEPT,
        COND_LOOP,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t                op;
        logic [ROUND_W-1:0] round;
    } ctrl_t;

    function automatic ucode_t micro_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        case (addr)
            ADDR_WAIT:   w = '{op: OP_WAIT,   cond: COND_ACCEPT, target: ADDR_SEED};
            ADDR_SEED:   w = '{op: OP_SEED,   cond: COND_NEXT,   target: ADDR_ABSORB};
            ADDR_ABSORB: w = '{op: OP_ABSORB, cond: COND_NEXT,   target: ADDR_MUL_LL};
            ADDR_MUL_LL: w = '{op: OP_MUL_LL, cond: COND_NEXT,   target: ADDR_MUL_LH};
            ADDR_MUL_LH: w = '{op: OP_MUL_LH, cond: COND_NEXT,   target: ADDR_MUL_HL};
            ADDR_MUL_HL: w = '{op: OP_MUL_HL, cond: COND_NEXT,   target: ADDR_FOLD};
            ADDR_FOLD:   w = '{op: OP_FOLD,   cond: COND_LOOP,   target: ADDR_ABSORB};
            ADDR_STEP:   w = '{op: OP_STEP,   cond: COND_JUMP,   target: ADDR_WAIT};
            default:     w = '{op: OP_WAIT,   cond: COND_JUMP,   target: ADDR_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/keyed_xorshift_stream_xor.sv =====
// Top level: keyed xorshift64 keystream XOR, one byte per transfer
//
// Input channel (in_valid/in_ready) carries data_in and start_of_message;
// output channel (out_valid/out_ready) carries data_out, one result per input.
// Configuration: pulse cfg_write_en with cfg_index 0 (key_low) or 1 (key_high)
// and the 64-bit value on cfg_data; the key is read only by the key schedule.
// A byte without start_of_message is stepped in its transfer cycle; its result
// is on data_out the next cycle, and one byte per cycle is sustained while
// out_ready stays high. A byte with start_of_message runs the key schedule
// first: seed, then 16 rounds of 5 microcode steps each, with the 64x64
// multiply done as three passes through one shared 32x32 multiplier; in_ready
// stays low until the result shows.
// A single output register holds the result; while the receiver stalls the
// block takes no new byte, and takes one in the cycle the result drains.
// Reset clears the keys and the stream state to zero; until a start byte
// arrives the keystream is zero and data passes unchanged.
`include "keyed_xorshift_stream_xor_macros.svh"

module keyed_xorshift_stream_xor
    import kxs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_in,
    input  logic        start_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_out
);

    ctrl_t       ctrl;
    logic        in_fire;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_data_reg;
    logic [7:0]  out_data_next;

    logic [63:0] xs_a;
    logic [63:0] xs_b;
    logic [63:0] xs_c;
    logic [63:0] key_word;
    logic [63:0] lane_mask;
    logic [31:0] mult_a;
    logic [31:0] mult_b;
    logic [63:0] prod;

    kxs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_fire),
        .start  (start_of_message),
        .ctrl   (ctrl)
    );

    assign in_ready  = (ctrl.op == OP_WAIT) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

    assign xs_a = state_reg ^ (state_reg << XS_A);
    assign xs_b = xs_a ^ (xs_a >> XS_B);
    assign xs_c = xs_b ^ (xs_b << XS_C);

    assign key_word  = ctrl.round[ROUND_W-1] ? key_high_reg : key_low_reg;
    assign lane_mask = 64'hFF << {ctrl.round[ROUND_W-2:0], 3'b000};

    assign mult_a = (ctrl.op == OP_MUL_HL) ? state_reg[63:32] : state_reg[31:0];
    assign mult_b = (ctrl.op == OP_MUL_LH) ? MIX_HI : MIX_LO;
    assign prod   = 64'(mult_a) * 64'(mult_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == REG_KEY_LOW))
            begin
                key_low_reg <= cfg_data;
            end
            if (cfg_write_en && (cfg_index == REG_KEY_HIGH))
            begin
                key_high_reg <= cfg_data;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        hold_next      = in_fire ? data_in : hold_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_fire && !start_of_message)
                begin
                    state_next     = xs_c;
                    out_valid_next = 1'b1;
                    out_data_next  = data_in ^ xs_c[7:0];
                end
            end
            OP_SEED:   state_next = SEED_CONST;
            OP_ABSORB: state_next = state_reg ^ (key_word & lane_mask);
            OP_MUL_LL: acc_next   = prod;
            OP_MUL_LH: acc_next   = acc_reg + {prod[31:0], 32'b0};
            OP_MUL_HL: state_next = acc_reg + {prod[31:0], 32'b0};
            OP_FOLD:   state_next = state_reg ^ (state_reg >> FOLD_SHIFT);
            OP_STEP:
            begin
                state_next     = xs_c;
                out_valid_next = 1'b1;
                out_data_next  = hold_reg ^ xs_c[7:0];
            end
            default:   state_next = state_reg;
        endcase
    end

    `KXS_ASSERT_NEXT(a_start_blocks_input, in_fire && start_of_message, !in_ready,
        "input taken again during key schedule")
    `KXS_ASSERT_NEXT(a_plain_byte_result, in_fire && !start_of_message, out_valid_reg,
        "no result the cycle after a plain byte transfer")
    `KXS_ASSERT_NOW(a_step_slot_free, ctrl.op == OP_STEP, !out_valid_reg,
        "keystream step would overwrite a pending result")

endmodule

// ===== rtl/core/kxs_seq.sv =====
// Microcode sequencer: step counter, round counter and control ROM
module kxs_seq
    import kxs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  start,
    output ctrl_t ctrl
);

    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    ucode_t             uword;

    assign uword = micro_rom(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= ADDR_WAIT;
            round_reg <= '0;
        end
        else
        begin
            pc_reg    <= pc_next;
            round_reg <= round_next;
        end
    end

    always_comb
    begin
        pc_next    = pc_reg + PC_W'(1);
        round_next = round_reg;
        case (uword.cond)
            COND_NEXT:   pc_next = pc_reg + PC_W'(1);
            COND_ACCEPT: pc_next = (accept && start) ? uword.target : pc_reg;
            COND_LOOP:   pc_next = (round_reg != LAST_ROUND) ? uword.target
                                                             : pc_reg + PC_W'(1);
            COND_JUMP:   pc_next = uword.target;
            default:     pc_next = ADDR_WAIT;
        endcase
        case (uword.op)
            OP_SEED: round_next = '0;
            OP_FOLD: round_next = round_reg + ROUND_W'(1);
            default: round_next = round_reg;
        endcase
    end

    assign ctrl.op    = uword.op;
    assign ctrl.round = round_reg;

endmodule
